/* sv/tdf_pkg.sv */
// shared definitions for the trial division factorizer
// controller state codes, command and status groups, default width
// no dependencies
package tdf_pkg;

  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef enum logic [5:0] {
    ST_IDLE        = 6'b000001,
    ST_CHECK       = 6'b000010,
    ST_DIV         = 6'b000100,
    ST_DECIDE      = 6'b001000,
    ST_EMIT_WHOLE  = 6'b010000,
    ST_EMIT_FACTOR = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic inc;
    logic emit_whole;
    logic emit_factor;
  } cmd_t;

  typedef struct packed {
    logic rem_le_one;
    logic div_done;
    logic d_gt_q;
    logic rem_zero;
    logic q_is_one;
    logic out_free;
  } status_t;

endpackage

/* sv/tdf_divider.sv */
// restoring divider, one quotient bit per cycle
// used by tdf_datapath; takes its default width from tdf_pkg
module tdf_divider #(
  parameter int DATA_WIDTH = tdf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] p;
  logic [DATA_WIDTH-1:0] q;
  logic [DATA_WIDTH-1:0] dsr;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [DATA_WIDTH:0]   shifted;
  logic                  ge;

  assign shifted = {p, q[DATA_WIDTH-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p   <= '0;
      q   <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (ge) begin
        p <= DATA_WIDTH'(shifted - {1'b0, dsr});
        q <= {q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        p <= shifted[DATA_WIDTH-1:0];
        q <= {q[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = q;
  assign remainder = p;

endmodule

/* sv/tdf_datapath.sv */
// datapath: remaining value, trial divisor, divider and output register
// depends on tdf_pkg and tdf_divider
module tdf_datapath #(
  parameter int DATA_WIDTH = tdf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tdf_pkg::cmd_t         cmd,
  output tdf_pkg::status_t      status,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] prime_factor,
  output logic                  negative,
  output logic                  last
);

  logic [DATA_WIDTH-1:0] remaining;
  logic [DATA_WIDTH-1:0] trial_divisor;
  logic                  neg;
  logic                  first_pending;
  logic [DATA_WIDTH-1:0] mag;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] remainder;

  assign mag = value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;

  tdf_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (remaining),
    .divisor   (trial_divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b0;
      remaining     <= '0;
      trial_divisor <= DATA_WIDTH'(2);
    end else if (cmd.load) begin
      remaining     <= mag;
      trial_divisor <= DATA_WIDTH'(2);
      neg           <= value[DATA_WIDTH-1];
      first_pending <= 1'b1;
    end else begin
      if (cmd.inc) begin
        trial_divisor <= trial_divisor + DATA_WIDTH'(1);
      end
      if (cmd.emit_whole) begin
        remaining     <= DATA_WIDTH'(1);
        first_pending <= 1'b0;
      end else if (cmd.emit_factor) begin
        remaining     <= quotient;
        first_pending <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_whole || cmd.emit_factor) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_whole) begin
      prime_factor <= remaining;
      negative     <= neg && first_pending;
      last         <= 1'b1;
    end else if (cmd.emit_factor) begin
      prime_factor <= trial_divisor;
      negative     <= neg && first_pending;
      last         <= quotient == DATA_WIDTH'(1);
    end
  end

  assign status.rem_le_one = remaining <= DATA_WIDTH'(1);
  assign status.div_done   = div_done;
  assign status.d_gt_q     = trial_divisor > quotient;
  assign status.rem_zero   = remainder == '0;
  assign status.q_is_one   = quotient == DATA_WIDTH'(1);
  assign status.out_free   = !out_valid || !out_stall;

endmodule

/* sv/tdf_controller.sv */
// controller state machine sequencing load, divide, decide and emit
// depends on tdf_pkg
module tdf_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tdf_pkg::status_t  status,
  output tdf_pkg::cmd_t     cmd
);

  tdf_pkg::state_t state;
  tdf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      tdf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tdf_pkg::ST_CHECK;
        end
      end
      tdf_pkg::ST_CHECK: begin
        if (status.rem_le_one) begin
          state_next = tdf_pkg::ST_EMIT_WHOLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = tdf_pkg::ST_DIV;
        end
      end
      tdf_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = tdf_pkg::ST_DECIDE;
        end
      end
      tdf_pkg::ST_DECIDE: begin
        if (status.d_gt_q) begin
          state_next = tdf_pkg::ST_EMIT_WHOLE;
        end else if (status.rem_zero) begin
          state_next = tdf_pkg::ST_EMIT_FACTOR;
        end else begin
          cmd.inc    = 1'b1;
          state_next = tdf_pkg::ST_CHECK;
        end
      end
      tdf_pkg::ST_EMIT_WHOLE: begin
        if (status.out_free) begin
          cmd.emit_whole = 1'b1;
          state_next     = tdf_pkg::ST_IDLE;
        end
      end
      tdf_pkg::ST_EMIT_FACTOR: begin
        if (status.out_free) begin
          cmd.emit_factor = 1'b1;
          state_next      = status.q_is_one ? tdf_pkg::ST_IDLE : tdf_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = tdf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/trial_division_factorizer.sv */
// top level of the trial division factorizer
// depends on tdf_pkg, tdf_controller, tdf_datapath
//
// One transaction in carries a signed value; the block answers with its prime
// factors of the magnitude in ascending order with repeats, one transaction
// each, last set on the final one and negative set on the first one for a
// negative input. Zero and plus or minus one give a single result of 0 or 1;
// the most negative value is taken as 2^(DATA_WIDTH-1). Each divisor trial
// goes through a check state, one pass of a shared restoring divider and a
// decide state, each result adds an emit state and each run starts with the
// accepting idle state, so zero and plus or minus one pass only through the
// idle, check and emit states. A run needs one trial per result plus one per
// step of the divisor from 2 up to about the larger of the second largest
// prime factor (counted with repeats) and the square root of the largest.
// Output waits on out_stall hold the controller; a new value is taken once
// the previous run's last result is in the output register.
module trial_division_factorizer #(
  parameter int DATA_WIDTH = tdf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] prime_factor,
  output logic                  negative,
  output logic                  last
);

  tdf_pkg::cmd_t    cmd;
  tdf_pkg::status_t status;

  tdf_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tdf_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .prime_factor (prime_factor),
    .negative     (negative),
    .last         (last)
  );

endmodule
